>>> sv/mepd_pkg.sv
// types and constants shared by the excursion peak detector modules
// no dependencies
package mepd_pkg;

    localparam int CH_W     = 6;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 48;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // excursion direction codes
    localparam logic [1:0] DIR_BETWEEN = 2'b00;
    localparam logic [1:0] DIR_ABOVE   = 2'b01;
    localparam logic [1:0] DIR_BELOW   = 2'b11;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] low;
        logic signed [SAMPLE_W-1:0] high;
    } thr_t;

    typedef struct packed {
        logic [1:0]                 dir;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic [TIME_W-1:0]          peak_time;
    } exc_state_t;

    typedef struct packed {
        logic emit;
        logic exc_we;
    } upd_ctrl_t;

endpackage

>>> sv/mepd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mepd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mepd_update.sv
// per-sample excursion update: threshold compares, peak tracking, event decision
// depends on mepd_pkg
module mepd_update (
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] sample,
    input  mepd_pkg::thr_t                       thr,
    input  mepd_pkg::exc_state_t                 cur,
    input  logic [mepd_pkg::TIME_W-1:0]          frame,
    output mepd_pkg::exc_state_t                 nxt,
    output mepd_pkg::upd_ctrl_t                  ctrl
);
    import mepd_pkg::*;

    logic hi_hit;
    logic lo_hit;

    assign hi_hit = $signed(sample) >= $signed(thr.high);
    assign lo_hit = $signed(sample) <  $signed(thr.low);

    always_comb begin
        nxt         = cur;
        ctrl.emit   = 1'b0;
        ctrl.exc_we = 1'b0;
        // high compare wins when thresholds overlap
        if (hi_hit) begin
            ctrl.emit = (cur.dir == DIR_BELOW);
            if ((cur.dir != DIR_ABOVE) || ($signed(sample) >= $signed(cur.peak_value))) begin
                ctrl.exc_we    = 1'b1;
                nxt.dir        = DIR_ABOVE;
                nxt.peak_value = sample;
                nxt.peak_time  = frame;
            end
        end else if (lo_hit) begin
            ctrl.emit = (cur.dir == DIR_ABOVE);
            if ((cur.dir != DIR_BELOW) || ($signed(sample) <= $signed(cur.peak_value))) begin
                ctrl.exc_we    = 1'b1;
                nxt.dir        = DIR_BELOW;
                nxt.peak_value = sample;
                nxt.peak_time  = frame;
            end
        end
    end

endmodule

>>> sv/multichannel_excursion_peak_detector_core.sv
// multichannel excursion peak detector, top level
// pipeline: a beat accepted into the stage 1 register yields its event (if any) on m_ from the output register
// throughput: one beat per cycle, held back only when the output register is full and not being drained
// reset: synchronous active-low aresetn clears direction and threshold valid bits,
// the frame counter and all handshake state; no clearing pass is needed
module multichannel_excursion_peak_detector_core #(
    parameter int NUM_CHANNELS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_command,
    input  logic [mepd_pkg::CH_W-1:0]            s_channel,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] s_sample,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] s_low_threshold,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] s_high_threshold,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mepd_pkg::CH_W-1:0]            m_event_channel,
    output logic [mepd_pkg::TIME_W-1:0]          m_peak_time,
    output logic signed [mepd_pkg::SAMPLE_W-1:0] m_peak_value
);
    import mepd_pkg::*;

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int THR_W = $bits(thr_t);
    localparam int EXC_W = $bits(exc_state_t);

    // ---------------------------------------------------------------
    // stage 1: input register, table reads land alongside it
    // ---------------------------------------------------------------
    logic                       s1_valid_reg;
    logic                       s1_cmd_reg;
    logic [CH_W-1:0]            s1_ch_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [SAMPLE_W-1:0] s1_low_reg;
    logic signed [SAMPLE_W-1:0] s1_high_reg;

    logic s_accept;
    logic s1_fire;

    logic m_valid_reg;

    // stage 1 moves on when the output register is empty or being drained
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg    <= s_command;
            s1_ch_reg     <= s_channel;
            s1_sample_reg <= s_sample;
            s1_low_reg    <= s_low_threshold;
            s1_high_reg   <= s_high_threshold;
        end
    end

    logic [CH_AW-1:0] s1_addr;
    logic             s1_in_range;
    logic             s1_is_sample;
    logic             s1_is_load;

    assign s1_addr      = CH_AW'(s1_ch_reg);
    assign s1_in_range  = 32'(s1_ch_reg) < NUM_CHANNELS;
    assign s1_is_sample = s1_in_range && (s1_cmd_reg == CMD_SAMPLE);
    assign s1_is_load   = s1_in_range && (s1_cmd_reg == CMD_LOAD);

    // ---------------------------------------------------------------
    // per-channel tables: threshold ram and excursion state ram
    // read at accept, written when stage 1 fires
    // ---------------------------------------------------------------
    logic             thr_we;
    logic             exc_we;
    thr_t             thr_wdata;
    exc_state_t       exc_wdata;
    logic [THR_W-1:0] thr_rdata;
    logic [EXC_W-1:0] exc_rdata;

    mepd_ram #(
        .WIDTH (THR_W),
        .DEPTH (NUM_CHANNELS)
    ) u_thr_ram (
        .aclk  (aclk),
        .we    (thr_we),
        .waddr (s1_addr),
        .wdata (thr_wdata),
        .re    (s_accept),
        .raddr (CH_AW'(s_channel)),
        .rdata (thr_rdata)
    );

    mepd_ram #(
        .WIDTH (EXC_W),
        .DEPTH (NUM_CHANNELS)
    ) u_exc_ram (
        .aclk  (aclk),
        .we    (exc_we),
        .waddr (s1_addr),
        .wdata (exc_wdata),
        .re    (s_accept),
        .raddr (CH_AW'(s_channel)),
        .rdata (exc_rdata)
    );

    // valid bits stand in for the reset value of each entry
    logic [NUM_CHANNELS-1:0] thr_valid_reg;
    logic [NUM_CHANNELS-1:0] exc_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_valid_reg <= '0;
            exc_valid_reg <= '0;
        end else begin
            if (thr_we) begin
                thr_valid_reg[s1_addr] <= 1'b1;
            end
            if (exc_we) begin
                exc_valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // bypass of the latest write: covers a read that shared its edge with the write
    logic             thr_fwd_valid_reg;
    logic [CH_AW-1:0] thr_fwd_addr_reg;
    thr_t             thr_fwd_data_reg;
    logic             exc_fwd_valid_reg;
    logic [CH_AW-1:0] exc_fwd_addr_reg;
    exc_state_t       exc_fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_fwd_valid_reg <= 1'b0;
            exc_fwd_valid_reg <= 1'b0;
        end else begin
            if (thr_we) begin
                thr_fwd_valid_reg <= 1'b1;
            end
            if (exc_we) begin
                exc_fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (thr_we) begin
            thr_fwd_addr_reg <= s1_addr;
            thr_fwd_data_reg <= thr_wdata;
        end
        if (exc_we) begin
            exc_fwd_addr_reg <= s1_addr;
            exc_fwd_data_reg <= exc_wdata;
        end
    end

    // effective table contents for the item in stage 1
    thr_t       thr_eff;
    exc_state_t exc_eff;

    always_comb begin
        if (!s1_in_range || !thr_valid_reg[s1_addr]) begin
            thr_eff = '0;
        end else if (thr_fwd_valid_reg && (thr_fwd_addr_reg == s1_addr)) begin
            thr_eff = thr_fwd_data_reg;
        end else begin
            thr_eff = thr_t'(thr_rdata);
        end
    end

    always_comb begin
        if (!s1_in_range || !exc_valid_reg[s1_addr]) begin
            // between thresholds, peak fields never read in this state
            exc_eff     = '0;
            exc_eff.dir = DIR_BETWEEN;
        end else if (exc_fwd_valid_reg && (exc_fwd_addr_reg == s1_addr)) begin
            exc_eff = exc_fwd_data_reg;
        end else begin
            exc_eff = exc_state_t'(exc_rdata);
        end
    end

    // ---------------------------------------------------------------
    // excursion update
    // ---------------------------------------------------------------
    logic [TIME_W-1:0] frame_counter_reg;
    exc_state_t        exc_nxt;
    upd_ctrl_t         upd_ctrl;

    mepd_update u_update (
        .sample (s1_sample_reg),
        .thr    (thr_eff),
        .cur    (exc_eff),
        .frame  (frame_counter_reg),
        .nxt    (exc_nxt),
        .ctrl   (upd_ctrl)
    );

    assign thr_we         = s1_fire && s1_is_load;
    assign thr_wdata.low  = s1_low_reg;
    assign thr_wdata.high = s1_high_reg;
    assign exc_we         = s1_fire && s1_is_sample && upd_ctrl.exc_we;
    assign exc_wdata      = exc_nxt;

    // frame time steps after the last channel's sample, saturating
    logic frame_step;

    assign frame_step = s1_fire && s1_is_sample
                     && (32'(s1_ch_reg) == NUM_CHANNELS - 1)
                     && (frame_counter_reg != TIME_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_counter_reg <= '0;
        end else if (frame_step) begin
            frame_counter_reg <= frame_counter_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic                       emit;
    logic [CH_W-1:0]            m_channel_reg;
    logic [TIME_W-1:0]          m_time_reg;
    logic signed [SAMPLE_W-1:0] m_value_reg;

    assign emit = s1_is_sample && upd_ctrl.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // the event reports the peak of the excursion that just ended
    always_ff @(posedge aclk) begin
        if (s1_fire && emit) begin
            m_channel_reg <= s1_ch_reg;
            m_time_reg    <= exc_eff.peak_time;
            m_value_reg   <= exc_eff.peak_value;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_channel = m_channel_reg;
    assign m_peak_time     = m_time_reg;
    assign m_peak_value    = m_value_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_event_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_fire))
        else $error("event beat appeared without stage 1 firing");

    a_frame_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (frame_counter_reg >= $past(frame_counter_reg)))
        else $error("frame counter went backward");

    a_event_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (32'(m_channel_reg) < NUM_CHANNELS))
        else $error("event beat carries a channel outside the table");

    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_ch_reg)))
        else $error("stalled stage 1 item was lost or overwritten");

endmodule

>>> tb/mepd_peak_checker.sv
// scoreboard for the excursion peak detector: predicts events from accepted input beats
// and compares every accepted output beat against them; depends on mepd_pkg
module mepd_peak_checker #(
    parameter int NUM_CHANNELS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_command,
    input  logic [mepd_pkg::CH_W-1:0]            s_channel,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] s_sample,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] s_low_threshold,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] s_high_threshold,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [mepd_pkg::CH_W-1:0]            m_event_channel,
    input  logic [mepd_pkg::TIME_W-1:0]          m_peak_time,
    input  logic signed [mepd_pkg::SAMPLE_W-1:0] m_peak_value,
    input  logic                                 finish_req,
    output int                                   fail_count,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mepd_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic [TIME_W-1:0]          ptime;
        logic signed [SAMPLE_W-1:0] pval;
    } peak_event_t;

    logic [1:0]                 dir_tab      [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] peak_val_tab [NUM_CHANNELS];
    logic [TIME_W-1:0]          peak_time_tab[NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] lo_thr_tab   [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] hi_thr_tab   [NUM_CHANNELS];
    logic [TIME_W-1:0]          frame_no;

    peak_event_t pending_events[$];
    int          err_total = 0;
    logic        leftovers_checked = 1'b0;

    assign fail_count = err_total;

    task automatic close_excursion(input logic [CH_W-1:0] ch);
        peak_event_t ev;
        ev.ch    = ch;
        ev.ptime = peak_time_tab[ch];
        ev.pval  = peak_val_tab[ch];
        pending_events.push_back(ev);
    endtask

    task automatic track_peak(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp,
                              input logic cmd, input logic signed [SAMPLE_W-1:0] lo,
                              input logic signed [SAMPLE_W-1:0] hi);
        logic [1:0] d;
        if (int'(ch) >= NUM_CHANNELS)
            return;
        if (cmd == CMD_LOAD) begin
            lo_thr_tab[ch] = lo;
            hi_thr_tab[ch] = hi;
            return;
        end
        d = dir_tab[ch];
        // high test first, so overlapping thresholds count as above
        if (smp >= hi_thr_tab[ch]) begin
            if (d == DIR_BELOW)
                close_excursion(ch);
            if (d != DIR_ABOVE || smp >= peak_val_tab[ch]) begin
                dir_tab[ch]       = DIR_ABOVE;
                peak_val_tab[ch]  = smp;
                peak_time_tab[ch] = frame_no;
            end
        end else if (smp < lo_thr_tab[ch]) begin
            if (d == DIR_ABOVE)
                close_excursion(ch);
            if (d != DIR_BELOW || smp <= peak_val_tab[ch]) begin
                dir_tab[ch]       = DIR_BELOW;
                peak_val_tab[ch]  = smp;
                peak_time_tab[ch] = frame_no;
            end
        end
        if (int'(ch) == NUM_CHANNELS - 1 && frame_no != TIME_MAX)
            frame_no = frame_no + 1'b1;
    endtask

    always @(posedge aclk) begin
        peak_event_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                dir_tab[i]    = DIR_BETWEEN;
                lo_thr_tab[i] = '0;
                hi_thr_tab[i] = '0;
            end
            frame_no = '0;
            pending_events.delete();
        end else begin
            // output side first: an event never leaves in the cycle its beat enters
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event beat: channel %0d time %0d value %0d",
                           m_event_channel, m_peak_time, m_peak_value);
                    err_total++;
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_channel !== want.ch) begin
                        $error("event_channel mismatch: expected %0d, actual %0d",
                               want.ch, m_event_channel);
                        err_total++;
                    end
                    if (m_peak_time !== want.ptime) begin
                        $error("peak_time mismatch: expected %0d, actual %0d",
                               want.ptime, m_peak_time);
                        err_total++;
                    end
                    if (m_peak_value !== want.pval) begin
                        $error("peak_value mismatch: expected %0d, actual %0d",
                               want.pval, m_peak_value);
                        err_total++;
                    end
                end
            end
            if (s_valid && s_ready)
                track_peak(s_channel, s_sample, s_command, s_low_threshold, s_high_threshold);
            if (finish_req && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (pending_events.size() != 0) begin
                    $error("%0d expected event beats never arrived", pending_events.size());
                    err_total += pending_events.size();
                end
            end
        end
        outstanding <= pending_events.size();
    end

endmodule

>>> tb/multichannel_excursion_peak_detector_core_tb.sv
// top of the excursion peak detector testbench: clock, reset, beat stimulus, back-pressure
// and verdict; depends on mepd_pkg, the core and mepd_peak_checker
module multichannel_excursion_peak_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mepd_pkg::*;

    localparam int NUM_CHANNELS   = 64;
    localparam int RANDOM_BEATS   = 1600;
    localparam int HOLD_AT        = 400;   // receiver stalls long here
    localparam int PAUSE_AT       = 800;   // sender drains the pipe here
    localparam int QUIET_AT       = 1400;  // no idling from here on
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;

    logic                       aclk             = 1'b0;
    logic                       aresetn          = 1'b0;
    logic                       s_valid          = 1'b0;
    logic                       s_ready;
    logic                       s_command        = CMD_SAMPLE;
    logic [CH_W-1:0]            s_channel        = '0;
    logic signed [SAMPLE_W-1:0] s_sample         = '0;
    logic signed [SAMPLE_W-1:0] s_low_threshold  = '0;
    logic signed [SAMPLE_W-1:0] s_high_threshold = '0;
    logic                       m_valid;
    logic                       m_ready          = 1'b0;
    logic [CH_W-1:0]            m_event_channel;
    logic [TIME_W-1:0]          m_peak_time;
    logic signed [SAMPLE_W-1:0] m_peak_value;

    logic finish_req = 1'b0;
    int   fail_count;
    int   outstanding;

    // idling controls for the sender and the receiver
    logic quiet    = 1'b0;   // end of run: nobody idles
    logic tx_gaps  = 1'b1;   // sender idles in this block of beats
    int   rx_hold_reqs  = 0;
    int   rx_holds_done = 0;
    int   cycle_cnt     = 0;

    int                         i;
    int                         pick;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;

    always #5 aclk = ~aclk;

    multichannel_excursion_peak_detector_core #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_channel       (s_channel),
        .s_sample        (s_sample),
        .s_low_threshold (s_low_threshold),
        .s_high_threshold(s_high_threshold),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_channel (m_event_channel),
        .m_peak_time     (m_peak_time),
        .m_peak_value    (m_peak_value)
    );

    mepd_peak_checker #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) peak_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_channel       (s_channel),
        .s_sample        (s_sample),
        .s_low_threshold (s_low_threshold),
        .s_high_threshold(s_high_threshold),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_channel (m_event_channel),
        .m_peak_time     (m_peak_time),
        .m_peak_value    (m_peak_value),
        .finish_req      (finish_req),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random ready bursts, plus one long hold-off counted here
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_holds_done < rx_hold_reqs) begin
                rx_holds_done++;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    // offer one beat, maybe after a short gap, and hold it until accepted
    task automatic send_beat(input logic cmd, input logic [CH_W-1:0] chn,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic signed [SAMPLE_W-1:0] lo_t,
                             input logic signed [SAMPLE_W-1:0] hi_t);
        if (!quiet && tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_channel        <= chn;
        s_sample         <= smp;
        s_low_threshold  <= lo_t;
        s_high_threshold <= hi_t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // unused fields of each beat carry random bits so every bit toggles
    task automatic send_sample(input logic [CH_W-1:0] chn, input logic signed [SAMPLE_W-1:0] smp);
        send_beat(CMD_SAMPLE, chn, smp, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_load(input logic [CH_W-1:0] chn, input logic signed [SAMPLE_W-1:0] lo_t,
                             input logic signed [SAMPLE_W-1:0] hi_t);
        send_beat(CMD_LOAD, chn, 16'($urandom), lo_t, hi_t);
    endtask

    // a handful of busy channels, with channel 63 often enough to move the frame clock
    function automatic logic [CH_W-1:0] hot_channel();
        if ($urandom_range(0, 7) == 0)
            return CH_W'(NUM_CHANNELS - 1);
        return CH_W'($urandom_range(0, 9));
    endfunction

    // value spread around zero, where the sensible thresholds sit
    function automatic logic signed [SAMPLE_W-1:0] near_zero(input int span);
        return SAMPLE_W'($urandom_range(0, 2 * span)) - SAMPLE_W'(span);
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset thresholds are zero, so zero counts as above
        send_sample(6'd0, 16'sd0);
        send_sample(6'd0, SMP_MIN);
        send_sample(6'd0, SMP_MAX);
        send_sample(6'd0, -16'sd1);
        // sample equal to the high threshold, then an equal peak in a later frame
        send_load(6'd1, -16'sd100, 16'sd100);
        send_sample(6'd1, 16'sd100);
        send_sample(6'd63, 16'sd0);
        send_sample(6'd1, 16'sd100);
        send_sample(6'd1, 16'sd99);
        send_sample(6'd1, 16'sd0);
        // a threshold load mid-excursion leaves the stored peak alone
        send_load(6'd1, -16'sd50, 16'sd50);
        send_sample(6'd1, -16'sd101);
        send_sample(6'd63, SMP_MIN);
        send_sample(6'd1, -16'sd101);
        send_sample(6'd1, SMP_MIN);
        // low above high: both tests pass, the high one wins
        send_load(6'd2, 16'sd500, -16'sd500);
        send_sample(6'd2, 16'sd0);
        send_sample(6'd2, -16'sd600);
        send_sample(6'd2, SMP_MAX);
        // extreme thresholds
        send_load(6'd3, SMP_MIN, SMP_MAX);
        send_sample(6'd3, SMP_MAX);
        send_sample(6'd3, SMP_MIN);
        send_load(6'd3, SMP_MAX, SMP_MIN);
        send_sample(6'd3, SMP_MIN);
        send_load(6'd63, SMP_MIN, SMP_MIN);
        send_sample(6'd63, SMP_MAX);

        // random: mostly sample streams on busy channels with sane thresholds
        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 100 == 0)
                tx_gaps = ($urandom_range(0, 2) != 0);
            if (i == HOLD_AT)
                rx_hold_reqs++;
            if (i == PAUSE_AT) begin
                // sender stops until every predicted event has drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
            if (i == QUIET_AT)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                ch = hot_channel();
                lo = -SAMPLE_W'($urandom_range(50, 1500));
                hi = SAMPLE_W'($urandom_range(50, 1500));
                send_load(ch, lo, hi);
            end else if (pick < 7) begin
                send_load(hot_channel(), 16'($urandom), 16'($urandom));
            end else if (pick < 17) begin
                // noise over the whole channel range and every field
                send_beat(1'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            end else if (pick < 50) begin
                send_sample(hot_channel(), 16'($urandom));
            end else begin
                send_sample(hot_channel(), near_zero(2000));
            end
        end

        // drain, then leave room for any stray beat
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        finish_req <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> multichannel_excursion_peak_detector_core.f
sv/mepd_pkg.sv
sv/mepd_ram.sv
sv/mepd_update.sv
sv/multichannel_excursion_peak_detector_core.sv
tb/mepd_peak_checker.sv
tb/multichannel_excursion_peak_detector_core_tb.sv
